>>> hdl/ndx_pkg.sv
// Shared types, sizes and the microcode program of the Newton difference extrapolator.
// Used by ndx_useq, ndx_datapath and newton_difference_extrapolator_core; no dependencies.
package ndx_pkg;

	localparam int MAX_POINTS   = 8;
	localparam int SAMPLE_WIDTH = 24;
	localparam int MAX_SAMPLES  = 1024;

	localparam int PT_IDX_W = $clog2(MAX_POINTS);
	localparam int PT_CNT_W = $clog2(MAX_POINTS + 1);
	localparam int COUNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int CFG_W    = 4;
	localparam int PRED_W   = 64;
	// The exact value at x <= 1024 of a degree-7 polynomial through 24-bit samples stays
	// below 2^89 in magnitude, and so do all the running differences.
	localparam int ACC_W    = 96;

	localparam logic [CFG_W-1:0] NUM_POINTS_RST = CFG_W'(MAX_POINTS);

	localparam logic signed [PRED_W-1:0] PRED_MAX = {1'b0, {(PRED_W-1){1'b1}}};
	localparam logic signed [PRED_W-1:0] PRED_MIN = {1'b1, {(PRED_W-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last;
	} in_word_t;

	typedef struct packed {
		logic signed [PRED_W-1:0] prediction;
		logic                     saturated;
		logic                     too_few;
	} out_word_t;

	// Datapath operations selected by a control word.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_STEP,
		OP_EMIT
	} uop_t;

	// Jump conditions; a step jumps to its target when the condition holds, else falls through.
	typedef enum logic [2:0] {
		CD_ALWAYS,
		CD_NOT_LAST,
		CD_TOO_FEW,
		CD_DIFF_MORE,
		CD_STEP_MORE,
		CD_OUT_BUSY
	} ucond_t;

	localparam int UC_PC_W = 3;

	localparam logic [UC_PC_W-1:0] UA_WAIT = 3'd0;
	localparam logic [UC_PC_W-1:0] UA_LOAD = 3'd1;
	localparam logic [UC_PC_W-1:0] UA_DIFF = 3'd2;
	localparam logic [UC_PC_W-1:0] UA_STEP = 3'd3;
	localparam logic [UC_PC_W-1:0] UA_EMIT = 3'd4;
	localparam logic [UC_PC_W-1:0] UA_BACK = 3'd5;

	typedef struct packed {
		logic                accept;
		uop_t                op;
		ucond_t              cond;
		logic [UC_PC_W-1:0]  target;
	} ctrl_t;

	typedef struct packed {
		logic last_acc;
		logic too_few;
		logic diff_more;
		logic step_more;
		logic out_busy;
	} stat_t;

	// The program. Words not listed return to the wait step.
	function automatic ctrl_t ucode_word(input logic [UC_PC_W-1:0] pc);
		ctrl_t w;
		w = '{accept: 1'b0, op: OP_NONE, cond: CD_ALWAYS, target: UA_WAIT};
		unique case (pc)
			UA_WAIT: w = '{accept: 1'b1, op: OP_NONE, cond: CD_NOT_LAST,  target: UA_WAIT};
			UA_LOAD: w = '{accept: 1'b0, op: OP_LOAD, cond: CD_TOO_FEW,   target: UA_EMIT};
			UA_DIFF: w = '{accept: 1'b0, op: OP_DIFF, cond: CD_DIFF_MORE, target: UA_DIFF};
			UA_STEP: w = '{accept: 1'b0, op: OP_STEP, cond: CD_STEP_MORE, target: UA_STEP};
			UA_EMIT: w = '{accept: 1'b0, op: OP_EMIT, cond: CD_OUT_BUSY,  target: UA_EMIT};
			UA_BACK: w = '{accept: 1'b0, op: OP_NONE, cond: CD_ALWAYS,    target: UA_WAIT};
			default: w = '{accept: 1'b0, op: OP_NONE, cond: CD_ALWAYS,    target: UA_WAIT};
		endcase
		return w;
	endfunction

endpackage

>>> hdl/ndx_useq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on ndx_pkg for the control word, status group and program.
module ndx_useq
	import ndx_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t status,
	output ctrl_t ctrl
);

	logic [UC_PC_W-1:0] pc_q;
	logic               take;

	assign ctrl = ucode_word(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			CD_ALWAYS:    take = 1'b1;
			CD_NOT_LAST:  take = !status.last_acc;
			CD_TOO_FEW:   take = status.too_few;
			CD_DIFF_MORE: take = status.diff_more;
			CD_STEP_MORE: take = status.step_more;
			CD_OUT_BUSY:  take = status.out_busy;
			default:      take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UA_WAIT;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= UC_PC_W'(pc_q + UC_PC_W'(1));
		end
	end

`ifndef SYNTHESIS
	// Only the wait step lets a word in.
	a_accept_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.accept |-> pc_q == UA_WAIT)
		else $error("ndx_useq: input opened outside the wait step");
`endif

endmodule

>>> hdl/ndx_datapath.sv
// Datapath: sample store and count, eight difference lanes, loop counters, output register.
// Depends on ndx_pkg; driven by the control word of ndx_useq.
module ndx_datapath
	import ndx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_t            ctrl,
	output stat_t            status,
	input  logic             in_valid,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0]               cfg_q;
	logic [PT_CNT_W-1:0]            n_eff;
	logic signed [SAMPLE_WIDTH-1:0] store_q [MAX_POINTS];
	logic signed [ACC_W-1:0]        lane_q  [MAX_POINTS];
	logic [COUNT_W-1:0]             count_q;
	logic                           over_q;
	logic [COUNT_W-1:0]             x_q;
	logic [COUNT_W-1:0]             t_q;
	logic [PT_CNT_W-1:0]            pass_q;
	logic                           tf_q;
	logic                           cover_q;
	logic                           out_valid_q;
	out_word_t                      out_word_q;
	logic                           in_acc;
	logic                           emit_go;
	logic                           fits;
	out_word_t                      result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= NUM_POINTS_RST;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// A setting of zero uses one point; settings above the store size use the whole store.
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = PT_CNT_W'(1);
		end else if (PT_CNT_W'(cfg_q) > PT_CNT_W'(MAX_POINTS)) begin
			n_eff = PT_CNT_W'(MAX_POINTS);
		end else begin
			n_eff = PT_CNT_W'(cfg_q);
		end
	end

	assign in_acc  = in_valid && ctrl.accept;
	assign emit_go = (ctrl.op == OP_EMIT) && !status.out_busy;

	assign status.last_acc  = in_acc && in_word.last;
	assign status.too_few   = count_q < COUNT_W'(n_eff);
	assign status.diff_more = PT_CNT_W'(pass_q + PT_CNT_W'(1)) < n_eff;
	assign status.step_more = COUNT_W'(t_q + COUNT_W'(1)) < x_q;
	assign status.out_busy  = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (in_acc && count_q < COUNT_W'(MAX_POINTS)) begin
			store_q[count_q[PT_IDX_W-1:0]] <= in_word.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			over_q  <= 1'b0;
			x_q     <= '0;
			t_q     <= '0;
			pass_q  <= '0;
			tf_q    <= 1'b0;
			cover_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (count_q < COUNT_W'(MAX_SAMPLES)) begin
					count_q <= COUNT_W'(count_q + COUNT_W'(1));
				end else begin
					over_q <= 1'b1;
				end
			end
			unique case (ctrl.op)
				OP_LOAD: begin
					x_q     <= count_q;
					tf_q    <= status.too_few;
					cover_q <= over_q;
					count_q <= '0;
					over_q  <= 1'b0;
					t_q     <= '0;
					pass_q  <= PT_CNT_W'(1);
				end
				OP_DIFF: begin
					if (pass_q < n_eff) begin
						pass_q <= PT_CNT_W'(pass_q + PT_CNT_W'(1));
					end
				end
				OP_STEP: begin
					if (t_q < x_q) begin
						t_q <= COUNT_W'(t_q + COUNT_W'(1));
					end
				end
				OP_NONE, OP_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Pass i of the table turns lanes i..n-1 into their next difference; a forward step then
	// moves every difference from position t to t+1 at once.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				for (int j = 0; j < MAX_POINTS; j++) begin
					lane_q[j] <= ACC_W'(store_q[j]);
				end
			end
			OP_DIFF: begin
				for (int j = 1; j < MAX_POINTS; j++) begin
					if (PT_CNT_W'(j) >= pass_q && PT_CNT_W'(j) < n_eff) begin
						lane_q[j] <= lane_q[j] - lane_q[j-1];
					end
				end
			end
			OP_STEP: begin
				if (t_q < x_q) begin
					for (int j = 0; j < MAX_POINTS - 1; j++) begin
						if (PT_CNT_W'(j + 1) < n_eff) begin
							lane_q[j] <= lane_q[j] + lane_q[j+1];
						end
					end
				end
			end
			OP_NONE, OP_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	assign fits = (&lane_q[0][ACC_W-1:PRED_W-1]) || !(|lane_q[0][ACC_W-1:PRED_W-1]);

	always_comb begin
		if (tf_q) begin
			result = '{prediction: '0, saturated: 1'b0, too_few: 1'b1};
		end else if (fits) begin
			result = '{prediction: lane_q[0][PRED_W-1:0], saturated: cover_q, too_few: 1'b0};
		end else begin
			result = '{prediction: lane_q[0][ACC_W-1] ? PRED_MIN : PRED_MAX,
				saturated: 1'b1, too_few: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	a_too_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.too_few |-> out_word.prediction == '0 && !out_word.saturated)
		else $error("ndx_datapath: short window word carries a value");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_SAMPLES))
		else $error("ndx_datapath: sample count ran past its limit");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		t_q <= x_q && pass_q <= PT_CNT_W'(MAX_POINTS))
		else $error("ndx_datapath: loop counter ran past its end");
`endif

endmodule

>>> hdl/newton_difference_extrapolator_core.sv
// Top level of the Newton forward-difference extrapolator.
// Depends on ndx_pkg, ndx_useq and ndx_datapath.

// Feed a window of equally spaced signed samples, one word per cycle, with last set on the
// final one; one result word follows each window. The first num_points samples (1 to 8,
// reset 8) define a polynomial, which is evaluated exactly at x equal to the number of
// samples in the window (counted up to 1024; longer windows flag saturated). Results beyond
// the signed 64-bit range clip and flag saturated; a window shorter than num_points gives
// too_few with a zero prediction. Samples are taken one per cycle while the block waits for
// input. After the last sample the block loads the stored points, builds the difference
// table and steps it forward one position per cycle, then emits the result; the input
// stalls throughout, and a too-short window goes straight from the load to the emit.
// A finished result waits in an output register while the next window loads.
module newton_difference_extrapolator_core
	import ndx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	ctrl_t ctrl;
	stat_t status;

	assign in_stall = !ctrl.accept;

	ndx_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	ndx_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.in_valid  (in_valid),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for newton_difference_extrapolator_core: feeds sample windows, predicts
// each extrapolated word with exact wide-integer Newton sums and compares it with the block.
// Depends on ndx_pkg and the core RTL only.
module tb_top;
	import ndx_pkg::*;

	localparam int WIDE_W        = 128;
	localparam int SETTLE_CYCLES = 32;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [WIDE_W-1:0] WIDE_MAX = PRED_MAX;
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = PRED_MIN;

	typedef enum int {
		WIN_RANDOM,
		WIN_EXTREME,
		WIN_SMALL,
		WIN_MIXED
	} win_style_e;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_word_t         in_word;
	logic             out_valid;
	logic             out_stall;
	out_word_t        out_word;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	in_word_t  sample_q[$];
	out_word_t predictions[$];

	// Shadow of the block's state.
	logic signed [SAMPLE_WIDTH-1:0] win_points [MAX_POINTS];
	int                             win_count;
	logic                           win_long;
	logic [CFG_W-1:0]               points_cfg;

	logic in_fire;
	int   gap_left;
	bit   in_quiet;
	int   stall_left;
	bit   out_quiet;
	int   mismatches;
	int   cycles;

	newton_difference_extrapolator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic int draw_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Counts one accepted sample and, on the closing word of a window, predicts its result.
	task automatic absorb_sample(input in_word_t w);
		int                       n;
		int                       x;
		int                       i;
		int                       j;
		logic signed [WIDE_W-1:0] diff [MAX_POINTS];
		logic signed [WIDE_W-1:0] binom;
		logic signed [WIDE_W-1:0] total;
		out_word_t                res;
		if (win_count < MAX_POINTS)
			win_points[win_count] = w.sample;
		if (win_count < MAX_SAMPLES)
			win_count++;
		else
			win_long = 1'b1;
		if (!w.last)
			return;
		n = int'(points_cfg);
		if (n == 0)
			n = 1;
		else if (n > MAX_POINTS)
			n = MAX_POINTS;
		x = win_count;
		res = '0;
		if (x < n) begin
			res.too_few = 1'b1;
		end else begin
			for (i = 0; i < n; i++)
				diff[i] = win_points[i];
			for (i = 1; i < n; i++)
				for (j = n - 1; j >= i; j--)
					diff[j] = diff[j] - diff[j-1];
			// Binomial weights stay exact because each partial product is divisible by i.
			binom = 1;
			total = 0;
			for (i = 0; i < n; i++) begin
				if (i > 0)
					binom = binom * (x - i + 1) / i;
				total += binom * diff[i];
			end
			if (total > WIDE_MAX) begin
				res.prediction = PRED_MAX;
				res.saturated  = 1'b1;
			end else if (total < WIDE_MIN) begin
				res.prediction = PRED_MIN;
				res.saturated  = 1'b1;
			end else begin
				res.prediction = total[PRED_W-1:0];
			end
			if (win_long)
				res.saturated = 1'b1;
		end
		predictions = {predictions, res};
		win_count = 0;
		win_long  = 1'b0;
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input win_style_e style,
			input int k, input int phase);
		int r;
		case (style)
			WIN_EXTREME: begin
				return ((k + phase) % 2) ? SAMPLE_MIN : SAMPLE_MAX;
			end
			WIN_SMALL: begin
				return SAMPLE_WIDTH'($urandom_range(0, 15) - 8);
			end
			WIN_MIXED: begin
				r = $urandom_range(0, 3);
				if (r == 0)
					return SAMPLE_MAX;
				if (r == 1)
					return SAMPLE_MIN;
				if (r == 2)
					return '0;
				return SAMPLE_WIDTH'($urandom());
			end
			default: begin
				return SAMPLE_WIDTH'($urandom());
			end
		endcase
	endfunction

	task automatic push_word(input logic signed [SAMPLE_WIDTH-1:0] s, input logic is_last);
		in_word_t w;
		w.sample = s;
		w.last   = is_last;
		sample_q = {sample_q, w};
	endtask

	// Only the leading points shape the polynomial; later samples just advance the count.
	task automatic add_window(input int len, input win_style_e style);
		int k;
		int phase;
		phase = $urandom_range(0, 1);
		for (k = 0; k < len; k++)
			push_word((k < MAX_POINTS) ? pick_sample(style, k, phase)
				: SAMPLE_WIDTH'($urandom()), k == len - 1);
	endtask

	function automatic int window_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return $urandom_range(1, 3);
		if (r < 80)
			return $urandom_range(1, 12);
		if (r < 95)
			return $urandom_range(13, 40);
		return $urandom_range(41, 90);
	endfunction

	task automatic wait_idle();
		while (sample_q.size() != 0 || in_valid || predictions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_points(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we     <= 1'b0;
		points_cfg = v;
		@(posedge clk);
	endtask

	// Input side: record acceptance and feed the predictor.
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			absorb_sample(in_word);
	end

	// Sender: a word stays put until accepted, then a random gap may follow.
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (in_valid) begin
				gap_left = draw_gap(in_quiet);
				if ($urandom_range(0, 49) == 0)
					in_quiet = !in_quiet;
			end
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				in_word  <= sample_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			out_quiet = !out_quiet;
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = draw_gap(out_quiet);
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predictions.size() == 0) begin
				$error("result word with no prediction waiting");
				mismatches++;
			end else begin
				want = predictions.pop_front();
				if (out_word.prediction !== want.prediction) begin
					$error("prediction: expected %0d, got %0d", want.prediction,
						out_word.prediction);
					mismatches++;
				end
				if (out_word.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated,
						out_word.saturated);
					mismatches++;
				end
				if (out_word.too_few !== want.too_few) begin
					$error("too_few: expected %0b, got %0b", want.too_few, out_word.too_few);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int               p;
		int               w;
		int               k;
		int               len;
		int               nw;
		int               rand_items;
		logic [CFG_W-1:0] cfg;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_word    = '0;
		out_stall  = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		in_fire    = 1'b0;
		gap_left   = 0;
		in_quiet   = 1'b0;
		stall_left = 0;
		out_quiet  = 1'b0;
		mismatches = 0;
		cycles     = 0;
		win_count  = 0;
		win_long   = 1'b0;
		points_cfg = NUM_POINTS_RST;
		for (k = 0; k < MAX_POINTS; k++)
			win_points[k] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: a short window, an alternating extreme window and a flat one.
		push_word(SAMPLE_MAX, 1'b0);
		push_word(SAMPLE_MIN, 1'b0);
		push_word('0, 1'b1);
		add_window(MAX_POINTS, WIN_EXTREME);
		for (k = 0; k <= MAX_POINTS; k++)
			push_word(SAMPLE_MIN, k == MAX_POINTS);
		wait_idle();
		write_points(CFG_W'(1));
		push_word(SAMPLE_MAX, 1'b1);
		push_word(SAMPLE_MIN, 1'b0);
		push_word(SAMPLE_WIDTH'(5), 1'b1);
		wait_idle();
		// Zero points behaves as one.
		write_points('0);
		push_word(SAMPLE_MIN, 1'b1);

		rand_items = 0;
		p          = 0;
		while (p < 4 || rand_items < 1300) begin
			case (p)
				0: cfg = CFG_W'(15);
				1: cfg = CFG_W'(9);
				2: cfg = CFG_W'(2);
				3: cfg = CFG_W'(MAX_POINTS);
				4: cfg = CFG_W'(1);
				5: cfg = '0;
				default: cfg = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 15))
					: CFG_W'($urandom_range(1, MAX_POINTS));
			endcase
			wait_idle();
			write_points(cfg);
			if (p == 2) begin
				// Runs past the sample counter's ceiling.
				len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6);
				add_window(len, WIN_RANDOM);
				rand_items += len;
			end
			if (p == 3) begin
				// Alternating extremes far out overflow the 64-bit result.
				add_window(120, WIN_EXTREME);
				rand_items += 120;
			end
			nw = $urandom_range(2, 6);
			for (w = 0; w < nw; w++) begin
				len = window_length();
				add_window(len, win_style_e'($urandom_range(0, 3)));
				rand_items += len;
			end
			p++;
		end

		wait_idle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ndx_pkg.sv
hdl/ndx_useq.sv
hdl/ndx_datapath.sv
hdl/newton_difference_extrapolator_core.sv
tb/sv/tb_top.sv
